[src/eoq_pkg.sv]
// Package for the elevator order queue: field widths, codes, the
// controller/datapath command and status structs and the call routing rule.
// No dependencies.
package eoq_pkg;

  localparam int unsigned NUM_FLOORS = 4;
  localparam int unsigned FLOOR_W    = 2;
  localparam int unsigned TARGET_W   = 3;
  localparam int unsigned NUM_QUEUES = 3;

  localparam logic CMD_CALL   = 1'b0;
  localparam logic CMD_FINISH = 1'b1;

  localparam logic [1:0] BTN_HALL_UP   = 2'd0;
  localparam logic [1:0] BTN_HALL_DOWN = 2'd1;
  localparam logic [1:0] BTN_CAB       = 2'd2;

  localparam logic [1:0] ST_STANDBY       = 2'd0;
  localparam logic [1:0] ST_GO_TO         = 2'd1;
  localparam logic [1:0] ST_FLOOR_REACHED = 2'd2;

  localparam logic [1:0] DIR_STOP = 2'b00;
  localparam logic [1:0] DIR_UP   = 2'b01;
  localparam logic [1:0] DIR_DOWN = 2'b11;

  localparam logic [TARGET_W-1:0] NO_TARGET = 3'b111;

  typedef enum logic [1:0] {
    PLACE_NONE  = 2'd0,
    PLACE_ONWAY = 2'd1,
    PLACE_CAB   = 2'd2,
    PLACE_HALL  = 2'd3
  } place_t;

  typedef struct packed {
    logic load;
    logic scan;
    logic apply;
  } eoq_cmd_t;

  typedef struct packed {
    logic scan_last;
    logic out_busy;
  } eoq_status_t;

  function automatic place_t route_call(
    input logic [FLOOR_W-1:0] floor,
    input logic [1:0]         button,
    input logic [1:0]         ctrl_state,
    input logic [1:0]         direction,
    input logic [FLOOR_W-1:0] last_floor
  );
    logic   down;
    logic   up;
    logic   below;
    logic   above;
    place_t target;
    down   = (direction == DIR_DOWN);
    up     = (direction == DIR_UP);
    below  = down && (floor < last_floor);
    above  = up && (floor > last_floor);
    target = PLACE_NONE;
    if (ctrl_state == ST_STANDBY || ctrl_state == ST_FLOOR_REACHED) begin
      if (button == BTN_CAB) begin
        target = PLACE_CAB;
      end else if (button == BTN_HALL_UP || button == BTN_HALL_DOWN) begin
        target = PLACE_HALL;
      end
    end else if (ctrl_state == ST_GO_TO) begin
      if (button == BTN_CAB) begin
        target = (below || above) ? PLACE_ONWAY : PLACE_CAB;
      end else if (button == BTN_HALL_DOWN) begin
        target = below ? PLACE_ONWAY : PLACE_HALL;
      end else if (button == BTN_HALL_UP) begin
        target = above ? PLACE_ONWAY : PLACE_HALL;
      end
    end
    return target;
  endfunction

endpackage

[src/eoq_ctrl.sv]
// Sequencer for the elevator order queue: take an event, scan the queues,
// apply the update. Uses eoq_pkg.
module eoq_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  output logic                s_tready,
  input  eoq_pkg::eoq_status_t status,
  output eoq_pkg::eoq_cmd_t    cmd
);

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_SCAN  = 3'b010,
    S_APPLY = 3'b100
  } state_t;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    s_tready   = 1'b0;
    unique case (state)
      S_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          cmd.load   = 1'b1;
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (status.scan_last) begin
          state_next = S_APPLY;
        end
      end
      S_APPLY: begin
        if (!status.out_busy) begin
          cmd.apply  = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

[src/eoq_dpath.sv]
// Datapath of the elevator order queue: event register, three FIFO queues,
// duplicate scan, routing, pop and the output register. Uses eoq_pkg.
module eoq_dpath #(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  logic                clk,
  input  logic                rst,
  input  logic [15:0]         s_tdata,
  input  logic                s_tuser,
  output logic                m_tvalid,
  input  logic                m_tready,
  output logic [7:0]          m_tdata,
  input  eoq_pkg::eoq_cmd_t    cmd,
  output eoq_pkg::eoq_status_t status
);

  localparam int unsigned IDX_W = $clog2(QUEUE_DEPTH);
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned FW    = eoq_pkg::FLOOR_W;
  localparam int unsigned NQ    = eoq_pkg::NUM_QUEUES;

  logic                      cmd_r;
  logic [FW-1:0]             floor_r;
  logic [1:0]                button_r;
  logic [1:0]                state_r;
  logic [1:0]                dir_r;
  logic [FW-1:0]             last_r;
  logic [2:0]                sensed_r;
  logic                      stop_r;
  logic                      hit;
  logic [IDX_W-1:0]          idx;

  logic [FW-1:0]             item      [NQ][QUEUE_DEPTH];
  logic [FW-1:0]             item_next [NQ][QUEUE_DEPTH];
  logic [CNT_W-1:0]          cnt       [NQ];
  logic [CNT_W-1:0]          cnt_next  [NQ];

  logic                      hit_now;
  logic                      drop;
  logic                      popped;
  eoq_pkg::place_t           route;
  eoq_pkg::place_t           placed_next;
  logic [eoq_pkg::TARGET_W-1:0] target_next;

  logic                      out_valid;
  logic [eoq_pkg::TARGET_W-1:0] target_r;
  eoq_pkg::place_t           placed_r;
  logic                      removed_r;

  always_comb begin
    hit_now = 1'b0;
    for (int q = 0; q < NQ; q++) begin
      if (CNT_W'(idx) < cnt[q] && item[q][idx] == floor_r) begin
        hit_now = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cmd_r    <= s_tuser;
      floor_r  <= s_tdata[1:0];
      button_r <= s_tdata[3:2];
      state_r  <= s_tdata[5:4];
      dir_r    <= s_tdata[7:6];
      last_r   <= s_tdata[9:8];
      sensed_r <= s_tdata[12:10];
      stop_r   <= s_tdata[13];
      hit      <= 1'b0;
      idx      <= '0;
    end else if (cmd.scan) begin
      hit <= hit | hit_now;
      idx <= idx + IDX_W'(1);
    end
  end

  assign status.scan_last = (idx == IDX_W'(QUEUE_DEPTH - 1));
  assign status.out_busy  = out_valid && !m_tready;

  always_comb begin
    item_next   = item;
    cnt_next    = cnt;
    placed_next = eoq_pkg::PLACE_NONE;
    popped      = 1'b0;
    drop        = (dir_r == eoq_pkg::DIR_STOP && sensed_r == {1'b0, floor_r}) || stop_r ||
                  (32'(floor_r) >= eoq_pkg::NUM_FLOORS) || hit;
    route       = eoq_pkg::route_call(floor_r, button_r, state_r, dir_r, last_r);
    if (cmd_r == eoq_pkg::CMD_FINISH) begin
      for (int q = 0; q < NQ; q++) begin
        if (!popped && cnt[q] != '0 && item[q][0] == floor_r) begin
          popped = 1'b1;
          for (int i = 0; i < QUEUE_DEPTH - 1; i++) begin
            item_next[q][i] = item[q][i + 1];
          end
          item_next[q][QUEUE_DEPTH - 1] = '0;
          cnt_next[q] = cnt[q] - CNT_W'(1);
        end
      end
    end else if (!drop) begin
      for (int q = 0; q < NQ; q++) begin
        if (route == eoq_pkg::place_t'(q + 1) && cnt[q] != CNT_W'(QUEUE_DEPTH)) begin
          item_next[q][cnt[q][IDX_W-1:0]] = floor_r;
          cnt_next[q]                     = cnt[q] + CNT_W'(1);
          placed_next                     = route;
        end
      end
    end
    target_next = eoq_pkg::NO_TARGET;
    for (int q = NQ - 1; q >= 0; q--) begin
      if (cnt_next[q] != '0) begin
        target_next = {1'b0, item_next[q][0]};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.apply) begin
      item      <= item_next;
      target_r  <= target_next;
      placed_r  <= placed_next;
      removed_r <= popped;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int q = 0; q < NQ; q++) begin
        cnt[q] <= '0;
      end
      out_valid <= 1'b0;
    end else begin
      if (cmd.apply) begin
        cnt <= cnt_next;
      end
      if (cmd.apply) begin
        out_valid <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {2'b00, removed_r, placed_r, target_r};

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    cnt[0] <= CNT_W'(QUEUE_DEPTH) && cnt[1] <= CNT_W'(QUEUE_DEPTH) &&
    cnt[2] <= CNT_W'(QUEUE_DEPTH))
    else $error("queue count beyond depth");

  a_one_action: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(removed_r && placed_r != eoq_pkg::PLACE_NONE))
    else $error("event both placed and removed");

  a_empty_target: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((target_r == eoq_pkg::NO_TARGET) ==
                   (cnt[0] == '0 && cnt[1] == '0 && cnt[2] == '0)))
    else $error("next target disagrees with queue fill");

  a_apply_shows: assert property (@(posedge clk) disable iff (rst)
    cmd.apply |=> out_valid)
    else $error("result lost after update");
`endif

endmodule

[src/elevator_order_queue_core.sv]
// Top level of the elevator order queue: stream ports, sequencer and datapath.
// Depends on eoq_pkg, eoq_ctrl and eoq_dpath.
//
// Each event (call or finish) is registered at its transfer in, then walks the duplicate
// check, comparing one entry of each of the three queues per cycle, and then updates the
// queues in S_APPLY. A new event is taken only in S_IDLE, so one event is handled at a
// time. The result sits in an output register, so the next event is taken while it
// waits; an update stalls only while that register is full.
module elevator_order_queue_core #(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // floor[1:0], button[3:2], ctrl_state[5:4], direction[7:6],
  // last_floor[9:8], sensed_floor[12:10], stop_pressed[13], zero[15:14]
  input  logic [15:0] s_tdata,
  // cmd
  input  logic        s_tuser,
  output logic        m_tvalid,
  input  logic        m_tready,
  // next_target[2:0], placed_in[4:3], removed[5], zero[7:6]
  output logic [7:0]  m_tdata
);

  eoq_pkg::eoq_cmd_t    cmd;
  eoq_pkg::eoq_status_t status;

  eoq_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .status   (status),
    .cmd      (cmd)
  );

  eoq_dpath #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_dpath (
    .clk      (clk),
    .rst      (rst),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .cmd      (cmd),
    .status   (status)
  );

endmodule

[tb/elevator_order_queue_core_tb.sv]
// Testbench for elevator_order_queue_core: directed and random call and finish events,
// with every reply checked against a scoreboard that keeps the three order queues.
// Depends on eoq_pkg and the elevator_order_queue_core RTL.
module elevator_order_queue_core_tb;

  localparam int unsigned QDEPTH = 4;
  localparam int unsigned STALL_LIMIT = 2000;
  localparam int unsigned HOLD_CYCLES = 300;
  localparam int unsigned PHASE_EVENTS = 400;

  localparam logic [1:0] ST_OTHER    = 2'd3;
  localparam logic [1:0] BTN_NONE    = 2'd3;
  localparam logic [1:0] DIR_ODD     = 2'b10;
  localparam logic [2:0] SENSED_NONE = 3'b111;

  typedef struct packed {
    logic       stop;
    logic [2:0] sensed;
    logic [1:0] last;
    logic [1:0] dir;
    logic [1:0] st;
    logic [1:0] btn;
    logic [1:0] floor;
  } event_t;

  typedef struct {
    bit [2:0]        target;
    eoq_pkg::place_t placed;
    bit              removed;
  } reply_t;

  class call_queue_scoreboard;
    bit [1:0] onway_floors[$];
    bit [1:0] cab_floors[$];
    bit [1:0] hall_floors[$];
    reply_t   expected_replies[$];
    int       errors;

    function bit [2:0] next_target();
      if (onway_floors.size() != 0) return {1'b0, onway_floors[0]};
      if (cab_floors.size() != 0) return {1'b0, cab_floors[0]};
      if (hall_floors.size() != 0) return {1'b0, hall_floors[0]};
      return eoq_pkg::NO_TARGET;
    endfunction

    function bit holds(bit [1:0] f);
      foreach (onway_floors[i]) if (onway_floors[i] == f) return 1'b1;
      foreach (cab_floors[i]) if (cab_floors[i] == f) return 1'b1;
      foreach (hall_floors[i]) if (hall_floors[i] == f) return 1'b1;
      return 1'b0;
    endfunction

    function bit pop_head(bit [1:0] f);
      if (onway_floors.size() != 0 && onway_floors[0] == f) begin
        void'(onway_floors.pop_front());
        return 1'b1;
      end
      if (cab_floors.size() != 0 && cab_floors[0] == f) begin
        void'(cab_floors.pop_front());
        return 1'b1;
      end
      if (hall_floors.size() != 0 && hall_floors[0] == f) begin
        void'(hall_floors.pop_front());
        return 1'b1;
      end
      return 1'b0;
    endfunction

    function eoq_pkg::place_t append(eoq_pkg::place_t where, bit [1:0] f);
      case (where)
        eoq_pkg::PLACE_ONWAY: begin
          if (onway_floors.size() >= QDEPTH) return eoq_pkg::PLACE_NONE;
          onway_floors.push_back(f);
        end
        eoq_pkg::PLACE_CAB: begin
          if (cab_floors.size() >= QDEPTH) return eoq_pkg::PLACE_NONE;
          cab_floors.push_back(f);
        end
        eoq_pkg::PLACE_HALL: begin
          if (hall_floors.size() >= QDEPTH) return eoq_pkg::PLACE_NONE;
          hall_floors.push_back(f);
        end
        default: ;
      endcase
      return where;
    endfunction

    function void note_event(bit cmd, event_t ev);
      reply_t          r;
      bit              down;
      bit              up;
      bit              below;
      bit              above;
      eoq_pkg::place_t where;
      r.placed  = eoq_pkg::PLACE_NONE;
      r.removed = 1'b0;
      where     = eoq_pkg::PLACE_NONE;
      if (cmd == eoq_pkg::CMD_FINISH) begin
        r.removed = pop_head(ev.floor);
      end else if (!(ev.dir == eoq_pkg::DIR_STOP && ev.sensed == {1'b0, ev.floor}) &&
                   !ev.stop && !holds(ev.floor)) begin
        down  = (ev.dir == eoq_pkg::DIR_DOWN);
        up    = (ev.dir == eoq_pkg::DIR_UP);
        below = down && (ev.floor < ev.last);
        above = up && (ev.floor > ev.last);
        case (ev.st)
          eoq_pkg::ST_STANDBY, eoq_pkg::ST_FLOOR_REACHED: begin
            case (ev.btn)
              eoq_pkg::BTN_CAB:                             where = eoq_pkg::PLACE_CAB;
              eoq_pkg::BTN_HALL_UP, eoq_pkg::BTN_HALL_DOWN: where = eoq_pkg::PLACE_HALL;
              default:                                      ;
            endcase
          end
          eoq_pkg::ST_GO_TO: begin
            case (ev.btn)
              eoq_pkg::BTN_CAB: begin
                where = (below || above) ? eoq_pkg::PLACE_ONWAY : eoq_pkg::PLACE_CAB;
              end
              eoq_pkg::BTN_HALL_DOWN: begin
                where = below ? eoq_pkg::PLACE_ONWAY : eoq_pkg::PLACE_HALL;
              end
              eoq_pkg::BTN_HALL_UP: begin
                where = above ? eoq_pkg::PLACE_ONWAY : eoq_pkg::PLACE_HALL;
              end
              default: ;
            endcase
          end
          default: ;
        endcase
        r.placed = append(where, ev.floor);
      end
      r.target = next_target();
      expected_replies.push_back(r);
    endfunction

    function void check_reply(logic [7:0] data);
      reply_t want;
      if (expected_replies.size() == 0) begin
        errors++;
        $display("%0t: reply %h arrived with nothing expected", $time, data);
        return;
      end
      want = expected_replies.pop_front();
      if (data[2:0] !== want.target) begin
        errors++;
        $display("%0t: next_target expected %0d actual %0d", $time, want.target, data[2:0]);
      end
      if (data[4:3] !== want.placed) begin
        errors++;
        $display("%0t: placed_in expected %0d actual %0d", $time, want.placed, data[4:3]);
      end
      if (data[5] !== want.removed) begin
        errors++;
        $display("%0t: removed expected %0d actual %0d", $time, want.removed, data[5]);
      end
    endfunction

    function int pending();
      return expected_replies.size();
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [15:0] s_tdata = '0;
  logic        s_tuser = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [7:0]  m_tdata;

  call_queue_scoreboard sb;
  int tx_idle_pct;
  int rx_idle_pct;
  bit hold_req;
  bit hold_done;
  int hold_left;
  int stall_cycles;

  elevator_order_queue_core #(.QUEUE_DEPTH(QDEPTH)) dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always #5 clk = ~clk;

  always @(negedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (hold_left > 0) begin
      m_tready <= 1'b0;
      hold_left--;
    end else if (hold_req && !hold_done) begin
      hold_done = 1'b1;
      hold_left = HOLD_CYCLES - 1;
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) sb.check_reply(m_tdata);
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      stall_cycles = 0;
    end else begin
      stall_cycles++;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("FAIL");
        $finish;
      end
    end
  end

  task automatic send_event(input bit cmd, input event_t ev);
    @(negedge clk);
    while ($urandom_range(99) < tx_idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= cmd;
    s_tdata  <= {2'b00, ev};
    do @(posedge clk); while (!s_tready);
    sb.note_event(cmd, ev);
  endtask

  task automatic send_call(input logic [1:0] floor, input logic [1:0] btn,
                           input logic [1:0] st, input logic [1:0] dir,
                           input logic [1:0] last, input logic [2:0] sensed,
                           input logic stop);
    event_t ev;
    ev = '{stop: stop, sensed: sensed, last: last, dir: dir, st: st, btn: btn, floor: floor};
    send_event(eoq_pkg::CMD_CALL, ev);
  endtask

  task automatic send_finish(input logic [1:0] floor);
    logic [13:0] raw;
    event_t      ev;
    raw      = 14'($urandom_range(16383));
    ev       = raw;
    ev.floor = floor;
    send_event(eoq_pkg::CMD_FINISH, ev);
  endtask

  task automatic send_random();
    logic [13:0] raw;
    event_t      ev;
    bit          cmd;
    bit [2:0]    head;
    raw  = 14'($urandom_range(16383));
    ev   = raw;
    cmd  = ($urandom_range(99) < 40);
    head = sb.next_target();
    if (cmd) begin
      if (head != eoq_pkg::NO_TARGET && $urandom_range(3) != 0) ev.floor = head[1:0];
    end else begin
      ev.stop = ($urandom_range(19) == 0);
      if ($urandom_range(9) != 0) ev.st = 2'($urandom_range(2));
      if ($urandom_range(9) != 0) ev.btn = 2'($urandom_range(2));
      if ($urandom_range(9) != 0) begin
        case ($urandom_range(2))
          0:       ev.dir = eoq_pkg::DIR_STOP;
          1:       ev.dir = eoq_pkg::DIR_UP;
          default: ev.dir = eoq_pkg::DIR_DOWN;
        endcase
      end
      if ($urandom_range(3) != 0) begin
        ev.sensed = $urandom_range(1) ? SENSED_NONE : 3'($urandom_range(3));
      end
    end
    send_event(cmd, ev);
  endtask

  task automatic run_directed();
    send_finish(2'd0);
    send_call(2'd0, eoq_pkg::BTN_CAB, eoq_pkg::ST_STANDBY, eoq_pkg::DIR_STOP, 2'd0,
              SENSED_NONE, 1'b0);
    send_call(2'd0, eoq_pkg::BTN_HALL_UP, eoq_pkg::ST_STANDBY, eoq_pkg::DIR_UP, 2'd1,
              SENSED_NONE, 1'b0);
    send_call(2'd3, eoq_pkg::BTN_HALL_UP, eoq_pkg::ST_GO_TO, eoq_pkg::DIR_UP, 2'd1,
              SENSED_NONE, 1'b0);
    send_call(2'd1, eoq_pkg::BTN_HALL_DOWN, eoq_pkg::ST_GO_TO, eoq_pkg::DIR_DOWN, 2'd2,
              SENSED_NONE, 1'b0);
    send_call(2'd2, eoq_pkg::BTN_HALL_UP, eoq_pkg::ST_FLOOR_REACHED, eoq_pkg::DIR_STOP, 2'd3,
              3'd1, 1'b0);
    send_finish(2'd2);
    send_call(2'd2, eoq_pkg::BTN_CAB, eoq_pkg::ST_STANDBY, eoq_pkg::DIR_UP, 2'd0,
              SENSED_NONE, 1'b1);
    send_call(2'd2, eoq_pkg::BTN_CAB, eoq_pkg::ST_STANDBY, eoq_pkg::DIR_STOP, 2'd2,
              3'd2, 1'b0);
    send_call(2'd2, eoq_pkg::BTN_CAB, ST_OTHER, eoq_pkg::DIR_UP, 2'd0, SENSED_NONE, 1'b0);
    send_call(2'd2, BTN_NONE, eoq_pkg::ST_STANDBY, eoq_pkg::DIR_UP, 2'd0, SENSED_NONE, 1'b0);
    send_call(2'd2, eoq_pkg::BTN_CAB, eoq_pkg::ST_GO_TO, DIR_ODD, 2'd0, 3'd6, 1'b0);
    send_finish(2'd3);
    send_finish(2'd1);
    send_finish(2'd0);
    send_finish(2'd2);
    send_call(2'd3, eoq_pkg::BTN_CAB, eoq_pkg::ST_GO_TO, eoq_pkg::DIR_UP, 2'd3, 3'd4, 1'b0);
    send_call(2'd1, eoq_pkg::BTN_HALL_DOWN, eoq_pkg::ST_GO_TO, eoq_pkg::DIR_DOWN, 2'd0,
              3'd5, 1'b0);
    send_call(2'd0, eoq_pkg::BTN_HALL_UP, eoq_pkg::ST_GO_TO, eoq_pkg::DIR_UP, 2'd0,
              SENSED_NONE, 1'b0);
    send_call(2'd2, eoq_pkg::BTN_CAB, eoq_pkg::ST_GO_TO, eoq_pkg::DIR_STOP, 2'd1, 3'd3, 1'b0);
    send_finish(2'd1);
    send_finish(2'd3);
    send_finish(2'd0);
    send_finish(2'd2);
  endtask

  initial begin
    sb          = new();
    tx_idle_pct = 11;
    rx_idle_pct = 62;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    run_directed();
    repeat (PHASE_EVENTS) send_random();

    tx_idle_pct = 62;
    rx_idle_pct = 11;
    repeat (PHASE_EVENTS) send_random();

    tx_idle_pct = 0;
    rx_idle_pct = 0;
    hold_req    = 1'b1;
    repeat (PHASE_EVENTS) send_random();

    @(negedge clk);
    s_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

[sim.f]
src/eoq_pkg.sv
src/eoq_ctrl.sv
src/eoq_dpath.sv
src/elevator_order_queue_core.sv
tb/elevator_order_queue_core_tb.sv
